[rtl/core/stet_pkg.sv]
package stet_pkg;

  localparam int CAPACITY = 64;

  localparam int VAL_W    = 32;
  localparam int KIND_W   = 3;
  localparam int IDX_IN_W = 6;
  localparam int CNT_OUT_W = 7;
  localparam int ERR_W    = 2;

  localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;
  localparam int PFX_LVLS = $clog2(CAPACITY);

  localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PREPEND = 3'd1;
  localparam logic [KIND_W-1:0] KIND_APPEND  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd4;

  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_INDEX = 2'd2;

  // Phase strobes and operation shared by every cell of the row.
  typedef struct packed {
    logic              cmp;
    logic              shift;
    logic              chk;
    logic [KIND_W-1:0] kind;
    logic              ok;
  } stet_ctl_t;

endpackage

[rtl/core/stet_cell.sv]
module stet_cell (
  input  logic                             clk,
  input  stet_pkg::stet_ctl_t              ctl,
  input  logic signed [stet_pkg::VAL_W-1:0] val,
  input  logic [stet_pkg::CMP_W-1:0]        pos,
  input  logic [stet_pkg::CMP_W-1:0]        index,
  input  logic [stet_pkg::CMP_W-1:0]        count,
  input  logic signed [stet_pkg::VAL_W-1:0] left_entry,
  input  logic signed [stet_pkg::VAL_W-1:0] right_entry,
  input  logic                             lower_hit,
  output logic signed [stet_pkg::VAL_W-1:0] entry_r,
  output logic                             gt_r,
  output logic [stet_pkg::VAL_W-1:0]        rd_r,
  output logic                             ok_r
);
  import stet_pkg::*;

  logic signed [VAL_W-1:0] entry_nxt;
  logic                    gt_nxt;
  logic [VAL_W-1:0]        rd_nxt;
  logic                    ok_nxt;
  logic                    beyond;

  assign beyond = (pos >= count);

  always_comb begin
    gt_nxt    = gt_r;
    rd_nxt    = rd_r;
    ok_nxt    = ok_r;
    entry_nxt = entry_r;
    if (ctl.cmp) begin
      // Mark where this word lands or where the row closes up.
      case (ctl.kind)
        KIND_INSERT:  gt_nxt = beyond || (entry_r > val);
        KIND_PREPEND: gt_nxt = 1'b1;
        KIND_APPEND:  gt_nxt = beyond;
        KIND_REMOVE:  gt_nxt = (pos >= index);
        default:      gt_nxt = 1'b0;
      endcase
      rd_nxt = (pos == index) ? entry_r : '0;
    end
    if (ctl.shift && ctl.ok) begin
      if (ctl.kind inside {KIND_INSERT, KIND_PREPEND, KIND_APPEND}) begin
        if (lower_hit) begin
          entry_nxt = left_entry;
        end else if (gt_r) begin
          entry_nxt = val;
        end
      end else if (ctl.kind == KIND_REMOVE && gt_r) begin
        entry_nxt = right_entry;
      end
    end
    if (ctl.chk) begin
      ok_nxt = beyond || (pos == '0) || (entry_r > left_entry);
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    gt_r    <= gt_nxt;
    rd_r    <= rd_nxt;
    ok_r    <= ok_nxt;
  end

endmodule

[rtl/core/stet_prefix.sv]
module stet_prefix (
  input  logic [stet_pkg::CAPACITY-1:0] gt,
  output logic [stet_pkg::CAPACITY-1:0] lower_hit
);
  import stet_pkg::*;

  logic [CAPACITY-1:0] lvl [0:PFX_LVLS];

  // Log-depth prefix OR: bit i ends up set if any flag at or below i is set.
  always_comb begin
    lvl[0] = gt;
    for (int l = 0; l < PFX_LVLS; l++) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (i >= (1 << l)) begin
          lvl[l+1][i] = lvl[l][i] | lvl[l][i - (1 << l)];
        end else begin
          lvl[l+1][i] = lvl[l][i];
        end
      end
    end
  end

  // Exclusive form: set where some lower cell already holds a flag.
  assign lower_hit = {lvl[PFX_LVLS][CAPACITY-2:0], 1'b0};

endmodule

[rtl/core/sorted_table_engine_core.sv]
// Sorted table engine: an ordered table of up to CAPACITY signed 32-bit
// entries held in a row of cells. A word is taken when start is high and
// busy is low; busy then stays high until its result has been shown. Every
// word gives exactly one result, on the out_ ports for a single cycle with
// out_valid high; the receiver cannot stall it, so capture it then. The next
// word can be taken in the cycle after the strobe, not before, so a word is
// never taken while the last one is in flight. Each word runs a fixed phase
// sequence through the cell row: compare every cell against the word,
// resolve the landing point in a prefix network and shift the row, check
// neighbor order, then report. Entries at
// or beyond the count are never read, so the row needs no clearing after
// reset and is ready in the first cycle. Kinds 5 to 7 change nothing and
// report error 0; a full table or an index not below the count leaves the
// table as it was and reports the error code.
module sorted_table_engine_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [stet_pkg::KIND_W-1:0]           in_kind,
  input  logic signed [stet_pkg::VAL_W-1:0]     in_value,
  input  logic [stet_pkg::IDX_IN_W-1:0]         in_index,
  output logic                                 out_valid,
  output logic signed [stet_pkg::VAL_W-1:0]     out_read_value,
  output logic [stet_pkg::CNT_OUT_W-1:0]        out_entry_count,
  output logic                                 out_is_sorted,
  output logic [stet_pkg::ERR_W-1:0]            out_error
);
  import stet_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CMP   = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2;
  localparam logic [2:0] ST_CHK   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [KIND_W-1:0]       kind_r;
  logic signed [VAL_W-1:0] value_r;
  logic [IDX_IN_W-1:0]     index_r;
  logic [ERR_W-1:0]        err_r, err_nxt;
  logic signed [VAL_W-1:0] read_r, read_nxt;

  stet_ctl_t ctl;

  logic signed [VAL_W-1:0] entry [CAPACITY];
  logic [VAL_W-1:0]        rd    [CAPACITY];
  logic [CAPACITY-1:0]     gt_vec;
  logic [CAPACITY-1:0]     ok_vec;
  logic [CAPACITY-1:0]     lower_hit_vec;
  logic [VAL_W-1:0]        rd_or;

  logic [CMP_W-1:0] count_ext;
  logic [CMP_W-1:0] index_ext;
  logic             adds;

  assign count_ext = CMP_W'(count_r);
  assign index_ext = CMP_W'(index_r);
  assign adds = (kind_r == KIND_INSERT) || (kind_r == KIND_PREPEND) ||
                (kind_r == KIND_APPEND);

  assign ctl.cmp   = (state_r == ST_CMP);
  assign ctl.shift = (state_r == ST_SHIFT);
  assign ctl.chk   = (state_r == ST_CHK);
  assign ctl.kind  = kind_r;
  assign ctl.ok    = (err_r == ERR_NONE);

  // Row of cells; each one sees its neighbors' entries for shifting and
  // for the order check.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_entry;
    logic signed [VAL_W-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_entry = '0;
    end else begin : g_mid_l
      assign left_entry = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_mid_r
      assign right_entry = entry[i+1];
    end

    stet_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .val         (value_r),
      .pos         (CMP_W'(i)),
      .index       (index_ext),
      .count       (count_ext),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .lower_hit   (lower_hit_vec[i]),
      .entry_r     (entry[i]),
      .gt_r        (gt_vec[i]),
      .rd_r        (rd[i]),
      .ok_r        (ok_vec[i])
    );
  end

  // Resolve the first marked cell: it loads the word, cells past it move up.
  stet_prefix u_prefix (
    .gt        (gt_vec),
    .lower_hit (lower_hit_vec)
  );

  // Only the addressed cell holds a nonzero masked entry; merge them.
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | rd[i];
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    read_nxt  = read_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        // Check for a full table or a bad index before touching the row.
        err_nxt = ERR_NONE;
        if (adds && (count_r >= CNT_W'(CAPACITY))) begin
          err_nxt = ERR_FULL;
        end else if (((kind_r == KIND_REMOVE) || (kind_r == KIND_READ)) &&
                     (index_ext >= count_ext)) begin
          err_nxt = ERR_INDEX;
        end
        state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        read_nxt = '0;
        if (err_r == ERR_NONE) begin
          if (adds) begin
            count_nxt = count_r + CNT_W'(1);
          end else if (kind_r == KIND_REMOVE) begin
            count_nxt = count_r - CNT_W'(1);
          end else if (kind_r == KIND_READ) begin
            read_nxt = $signed(rd_or);
          end
        end
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Hold the accepted word for the whole sequence.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      kind_r  <= in_kind;
      value_r <= in_value;
      index_r <= in_index;
    end
    err_r  <= err_nxt;
    read_r <= read_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign out_read_value  = read_r;
  assign out_entry_count = CNT_OUT_W'(count_r);
  assign out_is_sorted   = &ok_vec;
  assign out_error       = err_r;

endmodule
